// ----- design/rlec_pkg.sv -----
// rlec_pkg: shared types and constants of the image channel run-length encoder
// used by rlec_front, rlec_queue, rlec_back and the top level
package rlec_pkg;

    localparam logic [2:0] MODE_PASS   = 3'd0;
    localparam logic [2:0] MODE_BINARY = 3'd1;
    localparam logic [2:0] MODE_NIBBLE = 3'd2;
    localparam logic [2:0] MODE_SIX    = 3'd3;
    localparam logic [2:0] MODE_BYTE   = 3'd4;
    localparam logic [2:0] MODE_RESET  = MODE_BYTE;

    localparam logic [7:0] BIN_THRESHOLD = 8'd127;
    localparam logic [7:0] BIN_HIGH_KEY  = 8'h80;
    localparam logic [7:0] NIBBLE_MASK   = 8'hf0;
    localparam logic [7:0] SIX_MASK      = 8'hfc;

    localparam logic [8:0] MAX_BINARY = 9'd128;
    localparam logic [8:0] MAX_NIBBLE = 9'd16;
    localparam logic [8:0] MAX_SIX    = 9'd4;
    localparam logic [8:0] MAX_BYTE   = 9'd256;

    // one queued unit of work: the code bytes caused by one pixel
    typedef struct packed {
        logic [3:0][7:0] code;      // bytes in output order, index 0 first
        logic [1:0]      last_idx;  // index of the final byte of this entry
        logic            last;      // final byte closes the channel
    } code_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- design/rlec_front.sv -----
// rlec_front: accepts pixels, keeps the open run and turns each run-closing or pass-through pixel into a code entry
// depends on rlec_pkg
module rlec_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           mode,
    input  logic                 clear_run,
    input  logic                 accept,
    input  logic [7:0]           pixel,
    input  logic                 last_pixel,
    output logic                 push,
    output rlec_pkg::code_entry_t entry
);

    logic [7:0] run_value_reg, run_value_next;
    logic [8:0] run_length_reg, run_length_next;

    logic       pass;
    logic       wide;
    logic [7:0] key;
    logic [8:0] max_len;
    logic       close_a;
    logic       close_b;
    logic [8:0] len_after;
    logic [8:0] len_b_m1;
    logic [8:0] len_a_m1;
    logic [7:0] lm_a;
    logic [7:0] lm_b;
    logic [1:0] n_a;
    logic [1:0] n_b;

    always_comb
    begin
        pass = 1'b0;
        key  = pixel;
        max_len = rlec_pkg::MAX_BYTE;
        unique case (mode)
            rlec_pkg::MODE_BINARY:
            begin
                key = (pixel >= rlec_pkg::BIN_THRESHOLD) ? rlec_pkg::BIN_HIGH_KEY : 8'h00;
                max_len = rlec_pkg::MAX_BINARY;
            end
            rlec_pkg::MODE_NIBBLE:
            begin
                key = pixel & rlec_pkg::NIBBLE_MASK;
                max_len = rlec_pkg::MAX_NIBBLE;
            end
            rlec_pkg::MODE_SIX:
            begin
                key = pixel & rlec_pkg::SIX_MASK;
                max_len = rlec_pkg::MAX_SIX;
            end
            rlec_pkg::MODE_BYTE:
            begin
                key = pixel;
                max_len = rlec_pkg::MAX_BYTE;
            end
            default:
            begin
                pass = 1'b1;
            end
        endcase
    end

    assign wide      = (mode == rlec_pkg::MODE_BYTE);
    assign close_a   = (run_length_reg != 9'd0) && (key != run_value_reg);
    assign len_after = close_a ? 9'd1 : run_length_reg + 9'd1;
    assign close_b   = (len_after >= max_len) || last_pixel;
    assign len_a_m1  = run_length_reg - 9'd1;
    assign len_b_m1  = len_after - 9'd1;
    assign lm_a      = len_a_m1[7:0];
    assign lm_b      = len_b_m1[7:0];
    assign n_a       = close_a ? (wide ? 2'd2 : 2'd1) : 2'd0;
    assign n_b       = close_b ? (wide ? 2'd2 : 2'd1) : 2'd0;

    // pack the closed runs back to back, older run first
    always_comb
    begin
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [2:0] total;
        a0 = wide ? run_value_reg : (run_value_reg | lm_a);
        a1 = lm_a;
        b0 = wide ? key : (key | lm_b);
        b1 = lm_b;
        total = {1'b0, n_a} + {1'b0, n_b};
        entry.code = {b1, b0, a1, a0};
        if (!close_a)
        begin
            entry.code = {8'h00, 8'h00, b1, b0};
        end
        else if (!wide)
        begin
            entry.code = {8'h00, b1, b0, a0};
        end
        entry.last_idx = total[1:0] - 2'd1;
        entry.last     = last_pixel;
        if (pass)
        begin
            entry.code     = {8'h00, 8'h00, 8'h00, pixel};
            entry.last_idx = 2'd0;
        end
    end

    assign push = accept && (pass || close_a || close_b);

    always_comb
    begin
        run_value_next  = run_value_reg;
        run_length_next = run_length_reg;
        if (clear_run)
        begin
            run_value_next  = 8'h00;
            run_length_next = 9'd0;
        end
        else if (accept && !pass)
        begin
            run_value_next  = key;
            run_length_next = close_b ? 9'd0 : len_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg  <= 8'h00;
            run_length_reg <= 9'd0;
        end
        else
        begin
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
        end
    end

endmodule

// ----- design/rlec_queue.sv -----
// rlec_queue: short register queue of code entries between front and back
// depends on rlec_pkg
module rlec_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rlec_pkg::code_entry_t  push_entry,
    input  logic                   pop,
    output rlec_pkg::code_entry_t  head,
    output rlec_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rlec_pkg::code_entry_t slots [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign head = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- design/rlec_back.sv -----
// rlec_back: walks the head entry byte by byte into a registered output stage
// depends on rlec_pkg
module rlec_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rlec_pkg::code_entry_t head,
    input  logic                  head_valid,
    output logic                  pop,
    output logic [1:0]            byte_idx,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_data,
    output logic                  out_last
);

    logic [1:0] byte_idx_reg, byte_idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_last_reg, out_last_next;
    logic       load;
    logic       at_end;

    assign load   = head_valid && (!out_valid_reg || out_ready);
    assign at_end = (byte_idx_reg == head.last_idx);
    assign pop    = load && at_end;

    always_comb
    begin
        byte_idx_next  = byte_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = head.code[byte_idx_reg];
            out_last_next  = head.last && at_end;
            byte_idx_next  = at_end ? 2'd0 : byte_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            byte_idx_reg  <= byte_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign byte_idx  = byte_idx_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- design/image_channel_rle_encoder_core.sv -----
// image_channel_rle_encoder_core: top level of the image channel run-length encoder
// depends on rlec_pkg, rlec_front, rlec_queue and rlec_back
//
//  channel   dir  signals                    content
//  s_axis    in   tvalid tready tdata tlast  tdata[7:0] pixel, tlast last_pixel
//  m_axis    out  tvalid tready tdata tlast  tdata[7:0] code_byte, tlast last_byte
//  apb       in   psel penable pwrite paddr  reg 0 coding_mode at byte address 0
//
// the front takes one pixel per cycle while the queue has room; each pixel yields
// zero to four code bytes (four only in byte-run mode, a key change plus last pixel)
// the back sends one code byte per cycle while the output is not stalled, so throughput
// is set by the single-byte output register: pass-through gives 1 byte per pixel, the
// binary, four-bit and six-bit modes up to 2 (a key change plus a run closed by last pixel),
// byte-run mode 2 per closed run and up to 4 on a key change plus last pixel
// reset clears the run state, the queue pointers and the output valid; mode resets to 4
// output stalls hold the output register, then fill the queue, then drop s_axis_tready
module image_channel_rle_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // pixel transfers
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] pixel
    input  logic        s_axis_tlast,    // last_pixel
    // code byte transfers
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] code_byte
    output logic        m_axis_tlast,    // last_byte
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0] coding_mode_reg, coding_mode_next;
    logic       cfg_write;
    logic       mode_sel;
    logic       accept;

    logic                    q_push;
    logic                    q_pop;
    rlec_pkg::code_entry_t   q_in;
    rlec_pkg::code_entry_t   q_head;
    rlec_pkg::queue_status_t q_status;
    logic [1:0]              byte_idx;

    // register 0 is the only one; anything from byte address 4 up is ignored
    assign pready    = 1'b1;
    assign mode_sel  = (paddr[2] == 1'b0);
    assign cfg_write = psel && penable && pwrite && pready && mode_sel;
    assign prdata    = mode_sel ? {29'd0, coding_mode_reg} : 32'd0;

    always_comb
    begin
        coding_mode_next = coding_mode_reg;
        if (cfg_write)
        begin
            coding_mode_next = pwdata[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coding_mode_reg <= rlec_pkg::MODE_RESET;
        end
        else
        begin
            coding_mode_reg <= coding_mode_next;
        end
    end

    // the front may push every cycle while a queue slot is free
    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    rlec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (coding_mode_reg),
        .clear_run  (cfg_write),
        .accept     (accept),
        .pixel      (s_axis_tdata),
        .last_pixel (s_axis_tlast),
        .push       (q_push),
        .entry      (q_in)
    );

    rlec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    rlec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (!q_status.empty),
        .pop        (q_pop),
        .byte_idx   (byte_idx),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

    // a push never lands on a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_status.full))
        else $error("push into full queue");

    // a pop only ever takes a present entry
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // pass-through pixels always produce an entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (coding_mode_reg == rlec_pkg::MODE_PASS)) |-> q_push)
        else $error("pass-through pixel dropped");

    // the byte walk stays inside the head entry
    assert property (@(posedge clk) disable iff (!rst_n)
        !q_status.empty |-> (byte_idx <= q_head.last_idx))
        else $error("byte index past end of entry");

endmodule
